// ===== rtl/core/fama_pkg.sv =====
// package: transaction types and command codes for the fraction unit
package fama_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned NumWidth = 33;
  localparam int unsigned DenWidth = 31;
  localparam int unsigned MagWidth = 32;

  localparam logic [1:0] CMD_REDUCE = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_MUL    = 2'd2;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [InWidth-1:0] first_num;
    logic signed [InWidth-1:0] first_den;
    logic signed [InWidth-1:0] second_num;
    logic signed [InWidth-1:0] second_den;
  } fama_in_t;

  typedef struct packed {
    logic signed [NumWidth-1:0] result_num;
    logic [DenWidth-1:0]        result_den;
    logic                       zero_den_error;
  } fama_out_t;

endpackage

// ===== rtl/core/fama_divider.sv =====
// shared restoring divider: one quotient bit per cycle
module fama_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fama_pkg::MagWidth-1:0] dividend,
  input  logic [fama_pkg::MagWidth-1:0] divisor,
  output logic                          done,
  output logic [fama_pkg::MagWidth-1:0] quotient,
  output logic [fama_pkg::MagWidth-1:0] remainder
);
  import fama_pkg::*;

  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  logic [MagWidth-1:0] quo_r, quo_nxt;
  logic [MagWidth-1:0] rem_r, rem_nxt;
  logic [MagWidth-1:0] dvs_r, dvs_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [MagWidth:0]   trial;
  logic [MagWidth:0]   shifted;

  // load on start, else one shift and subtract step while busy
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[MagWidth-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CntWidth'(MagWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MagWidth]) begin
        rem_nxt = trial[MagWidth-1:0];
        quo_nxt = {quo_r[MagWidth-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[MagWidth-1:0];
        quo_nxt = {quo_r[MagWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // done only follows a running divide
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("divider done without a running divide");
  // a running divide never sees a new start
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !start)
    else $error("divider restarted while busy");
  // counter is zero when idle
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> cnt_r == '0)
    else $error("divider counter left over");

endmodule

// ===== rtl/core/fraction_add_multiply_reduce.sv =====
// top level: fraction reduce, add and multiply with euclid gcd reduction
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  fama_in_t
//  out_     output     out_valid/out_stall fama_out_t
//
// one transaction runs the euclid remainder steps and then divides the numerator
// and the denominator by the gcd; the bit-serial divider sets its length.
// reset is synchronous, active low, and clears the sequencer and out_valid.
// in_stall is high while a transaction is in work or its result waits.
// the result register holds until out_stall is low.
module fraction_add_multiply_reduce #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fama_pkg::fama_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fama_pkg::fama_out_t out_data
);
  import fama_pkg::*;

  localparam int unsigned OpW = (OPERAND_WIDTH < InWidth) ? OPERAND_WIDTH : InWidth;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0]                cmd_r;
  logic signed [OpW-1:0]     n1_r, d1_r, n2_r, d2_r;
  logic signed [MagWidth-1:0] p1_r, p2_r, den_r;
  logic [MagWidth-1:0]       a_r, b_r, an_r, ad_r, rn_r;
  logic                      neg_r;
  logic                      out_valid_r;
  fama_out_t                 out_r;

  logic                div_start;
  logic [MagWidth-1:0] div_a, div_b, div_q, div_rem;
  logic                div_done;

  logic signed [MagWidth:0]   num_w;
  logic signed [MagWidth-1:0] den_w;
  logic [MagWidth-1:0]        an_w, ad_w;
  logic signed [NumWidth-1:0] rn_s;

  fama_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  // numerator and denominator after the product step (the first fraction for reduce)
  always_comb begin
    if (cmd_r == CMD_REDUCE) begin
      num_w = (MagWidth+1)'(n1_r);
      den_w = MagWidth'(d1_r);
    end else if (cmd_r == CMD_ADD) begin
      num_w = (MagWidth+1)'(p1_r) + (MagWidth+1)'(p2_r);
      den_w = den_r;
    end else begin
      num_w = (MagWidth+1)'(p1_r);
      den_w = den_r;
    end
    an_w = num_w[MagWidth] ? MagWidth'(-num_w) : num_w[MagWidth-1:0];
    ad_w = den_w[MagWidth-1] ? MagWidth'(-den_w) : den_w;
  end

  // divider start and operands by state
  always_comb begin
    div_start = 1'b0;
    div_a     = a_r;
    div_b     = b_r;
    unique case (state_r)
      S_SUM:   begin
        div_start = (den_w != '0) && (num_w != '0);
        div_a = an_w;
        div_b = ad_w;
      end
      S_GCD:   begin
        div_start = div_done;
        if (div_rem == '0) begin
          // gcd found: divide the numerator by it
          div_a = an_r;
          div_b = b_r;
        end else begin
          div_a = b_r;
          div_b = div_rem;
        end
      end
      S_DIVN:  begin
        div_start = div_done;
        div_a = ad_r;
        div_b = a_r;
      end
      default: ;
    endcase
  end

  assign rn_s = neg_r ? -NumWidth'(rn_r) : NumWidth'(rn_r);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r   <= in_data.command;
          n1_r    <= OpW'(in_data.first_num);
          d1_r    <= OpW'(in_data.first_den);
          n2_r    <= OpW'(in_data.second_num);
          d2_r    <= OpW'(in_data.second_den);
          state_r <= S_MUL;
        end
        S_MUL: begin
          p1_r    <= MagWidth'(n1_r) * (cmd_r[1] ? MagWidth'(n2_r) : MagWidth'(d2_r));
          p2_r    <= MagWidth'(d1_r) * MagWidth'(n2_r);
          den_r   <= MagWidth'(d1_r) * MagWidth'(d2_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          neg_r <= num_w[MagWidth] != den_w[MagWidth-1];
          an_r  <= an_w;
          ad_r  <= ad_w;
          a_r   <= an_w;
          b_r   <= ad_w;
          if (den_w == '0) begin
            out_r       <= '{result_num: '0, result_den: '0, zero_den_error: 1'b1};
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (num_w == '0) begin
            out_r       <= '{result_num: '0, result_den: DenWidth'(1), zero_den_error: 1'b0};
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD: if (div_done) begin
          if (div_rem == '0) begin
            // gcd is b_r: divide the numerator
            a_r     <= b_r;
            state_r <= S_DIVN;
            b_r     <= b_r;
          end else begin
            a_r <= b_r;
            b_r <= div_rem;
          end
        end
        S_DIVN: if (div_done) begin
          rn_r    <= div_q;
          state_r <= S_DIVD;
        end
        S_DIVD: if (div_done) begin
          out_r       <= '{result_num: rn_s, result_den: DenWidth'(div_q),
                           zero_den_error: 1'b0};
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the gcd step starts from a_r/b_r, first divide uses an/ad from S_SUM
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result is shown only in the output state
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> state_r == S_OUT)
    else $error("result valid outside output state");
  // a good result always has a nonzero denominator
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && !out_r.zero_den_error |-> out_r.result_den != '0)
    else $error("zero denominator without error flag");
  // an error result carries zero fields; this checks the numerator
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_r.zero_den_error |-> out_r.result_num == '0)
    else $error("error result with nonzero numerator");

endmodule
